>>> design/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/sbp_pkg.sv
package sbp_pkg;

	// Default widths of the time and shot counters
	localparam int TIME_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 16;

	// Fixed field widths
	localparam int SPEED_W     = 16;
	localparam int FIELD_W     = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	// Request commands
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_AUTO  = 2'd1,
		CMD_BURST = 2'd2,
		CMD_HALT  = 2'd3
	} cmd_t;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_MIN    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_MAX    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTEND_FAST  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTEND_SLOW  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_RETRACT_FAST = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_RETRACT_SLOW = 3'd5;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] SPEED_MIN_RST    = 16'd0;
	localparam logic [CFG_DATA_W-1:0] SPEED_MAX_RST    = 16'd100;
	localparam logic [CFG_DATA_W-1:0] EXTEND_FAST_RST  = 16'd20;
	localparam logic [CFG_DATA_W-1:0] EXTEND_SLOW_RST  = 16'd100;
	localparam logic [CFG_DATA_W-1:0] RETRACT_FAST_RST = 16'd20;
	localparam logic [CFG_DATA_W-1:0] RETRACT_SLOW_RST = 16'd100;

endpackage

>>> design/solenoid_burst_pulser.sv
// Channel   Direction  Handshake           Payload
// in        request    in_valid/in_stall   cmd, speed, shot_count, elapsed_ms
// out       result     out_valid/out_stall was_pushing, solenoid_on
// cfg       write      cfg_we              cfg_index, cfg_data
//
// Tick and halt requests are handled in the accepting cycle; the result is registered the cycle after.
// A start request is accepted, then makes two multiply (16 steps) and divide
// (TIME_BITS steps) passes of one shared add/subtract unit, each closed by S_FIN,
// and commits in S_HALF; a start with a degenerate speed range goes straight to S_HALF.
// Reset (arst_n low) clears all control state and loads the register defaults.
// in_stall is high while a start is in progress or a result waits under out_stall.
`include "assert_macros.svh"

module solenoid_burst_pulser #(
	parameter int TIME_BITS  = sbp_pkg::TIME_BITS_DEF,
	parameter int COUNT_BITS = sbp_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       cmd,
	input  logic [sbp_pkg::SPEED_W-1:0]      speed,
	input  logic [sbp_pkg::FIELD_W-1:0]      shot_count,
	input  logic [sbp_pkg::FIELD_W-1:0]      elapsed_ms,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             was_pushing,
	output logic                             solenoid_on,
	input  logic                             cfg_we,
	input  logic [sbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sbp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SW     = sbp_pkg::SPEED_W;
	localparam int TW     = TIME_BITS;
	localparam int PW     = SW + TW;
	localparam int UW     = PW + 1;
	localparam int STEP_W = $clog2(TW > SW ? TW : SW);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_FIN,
		S_HALF
	} state_t;

	// Configuration registers
	logic [SW-1:0] speed_min_q, speed_max_q;
	logic [TW-1:0] ext_fast_q, ext_slow_q, ret_fast_q, ret_slow_q;

	// Pulser state
	logic [TW-1:0]         hp_q;
	logic [TW-1:0]         cd_q;
	logic [COUNT_BITS-1:0] cyc_q;
	logic                  auto_q;
	logic                  drive_q;

	// Sequencer
	state_t                state_q;
	logic [STEP_W-1:0]     step_q;
	logic                  sel_q;
	logic [SW-1:0]         x_q, xs_q, span_q;
	logic [TW-1:0]         mag_q;
	logic                  neg_q;
	logic [PW-1:0]         pr_q;
	logic [TW-1:0]         ext_q, ret_q;
	logic                  burst_q;
	logic [COUNT_BITS-1:0] shots_q;
	logic                  push_q;
	logic                  out_valid_q;
	logic                  was_pushing_q;

	// Combinational helpers
	logic                  in_acc;
	logic [TW-1:0]         el;
	logic                  cyc_nz;
	logic                  pushing;
	logic [SW-1:0]         spd_cl;
	logic                  degen;
	logic                  pair_ret;
	logic [TW-1:0]         pair_fast, pair_slow, slow_cur;
	logic [TW:0]           diff, negd;
	logic                  pair_neg;
	logic [TW-1:0]         pair_mag;
	logic [UW-1:0]         unit_a, unit_b, unit_sum;
	logic                  unit_sub;
	logic                  cd_gt;
	logic                  div_ok;

	assign in_stall    = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign was_pushing = was_pushing_q;
	assign solenoid_on = drive_q;

	assign el      = TW'(elapsed_ms);
	assign cyc_nz  = (cyc_q != '0);
	assign pushing = auto_q || cyc_nz;
	assign degen   = (speed_max_q <= speed_min_q);

	// Clamp the speed, upper bound first
	always_comb begin
		priority if (speed > speed_max_q) begin
			spd_cl = speed_max_q;
		end else if (speed < speed_min_q) begin
			spd_cl = speed_min_q;
		end else begin
			spd_cl = speed;
		end
	end

	// Pick the time pair to load and take its signed difference apart
	assign pair_ret  = (state_q == S_FIN);
	assign pair_fast = pair_ret ? ret_fast_q : ext_fast_q;
	assign pair_slow = pair_ret ? ret_slow_q : ext_slow_q;
	assign slow_cur  = sel_q ? ret_slow_q : ext_slow_q;
	assign diff      = {1'b0, pair_fast} - {1'b0, pair_slow};
	assign negd      = -diff;
	assign pair_neg  = diff[TW];
	assign pair_mag  = pair_neg ? negd[TW-1:0] : diff[TW-1:0];

	// Shared add/subtract unit
	always_comb begin
		unit_a   = '0;
		unit_b   = '0;
		unit_sub = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				unit_a   = UW'(cd_q);
				unit_b   = UW'(el);
				unit_sub = 1'b1;
			end
			S_MUL: begin
				unit_a = UW'({pr_q[PW-2:0], 1'b0});
				unit_b = xs_q[SW-1] ? UW'(mag_q) : '0;
			end
			S_DIV: begin
				unit_a   = UW'(pr_q[PW-1:TW-1]);
				unit_b   = UW'(span_q);
				unit_sub = 1'b1;
			end
			S_FIN: begin
				unit_a   = UW'(slow_cur);
				unit_b   = UW'(pr_q[TW-1:0]);
				unit_sub = neg_q;
			end
			S_HALF: begin
				unit_a = UW'(ext_q);
				unit_b = UW'(ret_q);
			end
			default: begin
				unit_sub = 1'b0;
			end
		endcase
		unit_sum = unit_sub ? (unit_a - unit_b) : (unit_a + unit_b);
	end

	assign cd_gt  = !unit_sum[UW-1] && (unit_sum[TW-1:0] != '0);
	assign div_ok = !unit_sum[UW-1];

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_min_q <= sbp_pkg::SPEED_MIN_RST;
			speed_max_q <= sbp_pkg::SPEED_MAX_RST;
			ext_fast_q  <= TW'(sbp_pkg::EXTEND_FAST_RST);
			ext_slow_q  <= TW'(sbp_pkg::EXTEND_SLOW_RST);
			ret_fast_q  <= TW'(sbp_pkg::RETRACT_FAST_RST);
			ret_slow_q  <= TW'(sbp_pkg::RETRACT_SLOW_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				sbp_pkg::REG_SPEED_MIN:    speed_min_q <= cfg_data;
				sbp_pkg::REG_SPEED_MAX:    speed_max_q <= cfg_data;
				sbp_pkg::REG_EXTEND_FAST:  ext_fast_q  <= TW'(cfg_data);
				sbp_pkg::REG_EXTEND_SLOW:  ext_slow_q  <= TW'(cfg_data);
				sbp_pkg::REG_RETRACT_FAST: ret_fast_q  <= TW'(cfg_data);
				sbp_pkg::REG_RETRACT_SLOW: ret_slow_q  <= TW'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// Sequencer, pulser state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			sel_q         <= 1'b0;
			hp_q          <= '0;
			cd_q          <= '0;
			cyc_q         <= '0;
			auto_q        <= 1'b0;
			drive_q       <= 1'b0;
			out_valid_q   <= 1'b0;
			was_pushing_q <= 1'b0;
			burst_q       <= 1'b0;
			push_q        <= 1'b0;
		end else begin
			// Drop a result once taken
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (sbp_pkg::cmd_t'(cmd))
							sbp_pkg::CMD_TICK: begin
								out_valid_q   <= 1'b1;
								was_pushing_q <= pushing;
								if (el != '0) begin
									if (auto_q && cyc_nz) begin
										auto_q <= 1'b0;
									end
									if (pushing) begin
										if (cd_gt) begin
											cd_q <= unit_sum[TW-1:0];
										end else begin
											cd_q    <= hp_q;
											drive_q <= !drive_q;
											if (drive_q && cyc_nz) begin
												cyc_q <= cyc_q - 1'b1;
											end
										end
									end else begin
										drive_q <= 1'b0;
									end
								end
							end
							sbp_pkg::CMD_AUTO, sbp_pkg::CMD_BURST: begin
								push_q  <= pushing;
								burst_q <= (sbp_pkg::cmd_t'(cmd) == sbp_pkg::CMD_BURST);
								shots_q <= COUNT_BITS'(shot_count);
								if (degen) begin
									ext_q   <= ext_slow_q;
									ret_q   <= ret_slow_q;
									state_q <= S_HALF;
								end else begin
									x_q     <= spd_cl - speed_min_q;
									xs_q    <= spd_cl - speed_min_q;
									span_q  <= speed_max_q - speed_min_q;
									mag_q   <= pair_mag;
									neg_q   <= pair_neg;
									pr_q    <= '0;
									sel_q   <= 1'b0;
									step_q  <= STEP_W'(SW - 1);
									state_q <= S_MUL;
								end
							end
							sbp_pkg::CMD_HALT: begin
								out_valid_q   <= 1'b1;
								was_pushing_q <= pushing;
								auto_q        <= 1'b0;
								cyc_q         <= '0;
								cd_q          <= '0;
							end
						endcase
					end
				end
				// Shift-add one speed bit per step, MSB first
				S_MUL: begin
					pr_q <= unit_sum[PW-1:0];
					xs_q <= {xs_q[SW-2:0], 1'b0};
					if (step_q == '0) begin
						step_q  <= STEP_W'(TW - 1);
						state_q <= S_DIV;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				// Restoring divide by the span, one quotient bit per step
				S_DIV: begin
					pr_q <= {div_ok ? unit_sum[SW-1:0] : pr_q[PW-2:TW-1],
						pr_q[TW-2:0], div_ok};
					if (step_q == '0) begin
						state_q <= S_FIN;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				// Apply the signed quotient to the slow time
				S_FIN: begin
					if (!sel_q) begin
						ext_q   <= unit_sum[TW-1:0];
						sel_q   <= 1'b1;
						mag_q   <= pair_mag;
						neg_q   <= pair_neg;
						pr_q    <= '0;
						xs_q    <= x_q;
						step_q  <= STEP_W'(SW - 1);
						state_q <= S_MUL;
					end else begin
						ret_q   <= unit_sum[TW-1:0];
						state_q <= S_HALF;
					end
				end
				// Commit the half period and start pushing
				S_HALF: begin
					hp_q          <= unit_sum[TW:1];
					auto_q        <= 1'b1;
					out_valid_q   <= 1'b1;
					was_pushing_q <= push_q;
					if (cyc_nz) begin
						cd_q <= '0;
					end
					if (burst_q) begin
						cyc_q <= shots_q;
					end else begin
						cyc_q <= '0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPLIES(a_busy_stalls, clk, arst_n, state_q != S_IDLE, in_stall, "busy but not stalled")
	`ASSERT_IMPLIES(a_no_result_in_calc, clk, arst_n, state_q == S_MUL || state_q == S_DIV, !out_valid_q, "result pending during calculation")
	`ASSERT_IMPLIES(a_rem_below_span, clk, arst_n, state_q == S_DIV, pr_q[PW-1:TW] < span_q, "divide remainder not below span")
	`ASSERT_NEXT(a_commit_starts, clk, arst_n, state_q == S_HALF, auto_q && out_valid_q && state_q == S_IDLE, "start did not commit")

endmodule

>>> sim/solenoid_burst_pulser_tb.sv
`timescale 1ns / 100ps

module solenoid_burst_pulser_tb;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int SETTLE_CYCLES    = 80;
	localparam int PHASES           = 9;
	localparam int ITEMS_PER_PHASE  = 59;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int MAX_GAP          = 20;

	// Indexes past the last register; writes there must be ignored
	localparam logic [sbp_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [sbp_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic was_pushing;
		logic solenoid_on;
	} levels_t;

	// Track the pulser state and the drive levels each request must report
	class pulse_tracker;
		logic [15:0] spd_lo, spd_hi;
		logic [15:0] ext_fast, ext_slow, ret_fast, ret_slow;
		longint half_per;
		longint count_down;
		logic [15:0] shots_left;
		bit auto_on;
		bit drive_on;
		levels_t levels_due[$];
		int errors;
		int n_checked;
		int n_toggles;

		function new();
			spd_lo = sbp_pkg::SPEED_MIN_RST;
			spd_hi = sbp_pkg::SPEED_MAX_RST;
			ext_fast = sbp_pkg::EXTEND_FAST_RST;
			ext_slow = sbp_pkg::EXTEND_SLOW_RST;
			ret_fast = sbp_pkg::RETRACT_FAST_RST;
			ret_slow = sbp_pkg::RETRACT_SLOW_RST;
			half_per = 0;
			count_down = 0;
			shots_left = '0;
			auto_on = 0;
			drive_on = 0;
			errors = 0;
			n_checked = 0;
			n_toggles = 0;
		endfunction

		function void write_reg(logic [sbp_pkg::CFG_INDEX_W-1:0] idx,
				logic [sbp_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				sbp_pkg::REG_SPEED_MIN:    spd_lo = data;
				sbp_pkg::REG_SPEED_MAX:    spd_hi = data;
				sbp_pkg::REG_EXTEND_FAST:  ext_fast = data;
				sbp_pkg::REG_EXTEND_SLOW:  ext_slow = data;
				sbp_pkg::REG_RETRACT_FAST: ret_fast = data;
				sbp_pkg::REG_RETRACT_SLOW: ret_slow = data;
				default: ;
			endcase
		endfunction

		// Interpolate from the slow time at spd_lo to the fast time at spd_hi
		function longint map_ms(longint s, longint slow, longint fast);
			longint lo, hi;
			lo = longint'(spd_lo);
			hi = longint'(spd_hi);
			if (hi <= lo)
				return slow;
			return ((s - lo) * (fast - slow)) / (hi - lo) + slow;
		endfunction

		function void begin_push(logic [15:0] spd);
			longint s, ext, ret;
			s = longint'(spd);
			if (s > longint'(spd_hi))
				s = longint'(spd_hi);
			else if (s < longint'(spd_lo))
				s = longint'(spd_lo);
			ext = map_ms(s, longint'(ext_slow), longint'(ext_fast));
			ret = map_ms(s, longint'(ret_slow), longint'(ret_fast));
			half_per = (ext + ret) / 2;
			// A start during a burst halts the burst first
			if (shots_left != 0)
				stop_all();
			auto_on = 1;
		endfunction

		function void stop_all();
			auto_on = 0;
			shots_left = '0;
			count_down = 0;
		endfunction

		function void advance(logic [15:0] el);
			if (el == 0)
				return;
			if (auto_on && shots_left != 0)
				auto_on = 0;
			if (auto_on || shots_left != 0) begin
				count_down -= longint'(el);
				if (count_down <= 0) begin
					count_down = half_per;
					if (drive_on && shots_left != 0)
						shots_left--;
					drive_on = !drive_on;
					n_toggles++;
				end
			end else begin
				drive_on = 0;
			end
		endfunction

		function void take_request(sbp_pkg::cmd_t c, logic [15:0] spd, logic [15:0] shots,
				logic [15:0] el);
			levels_t lv;
			lv.was_pushing = auto_on || shots_left != 0;
			case (c)
				sbp_pkg::CMD_TICK:  advance(el);
				sbp_pkg::CMD_AUTO:  begin_push(spd);
				sbp_pkg::CMD_BURST: begin
					begin_push(spd);
					shots_left = shots;
				end
				default:   stop_all();
			endcase
			lv.solenoid_on = drive_on;
			levels_due.push_back(lv);
		endfunction

		function void check_levels(logic wp, logic on);
			levels_t lv;
			if (levels_due.size() == 0) begin
				$error("result with no request pending: was_pushing=%0b solenoid_on=%0b",
					wp, on);
				errors++;
				return;
			end
			lv = levels_due.pop_front();
			n_checked++;
			if (wp !== lv.was_pushing) begin
				$error("was_pushing mismatch: expected %0b, actual %0b", lv.was_pushing, wp);
				errors++;
			end
			if (on !== lv.solenoid_on) begin
				$error("solenoid_on mismatch: expected %0b, actual %0b", lv.solenoid_on, on);
				errors++;
			end
		endfunction

		function int pending();
			return levels_due.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [1:0]                      cmd = sbp_pkg::CMD_TICK;
	logic [sbp_pkg::SPEED_W-1:0]     speed = '0;
	logic [sbp_pkg::FIELD_W-1:0]     shot_count = '0;
	logic [sbp_pkg::FIELD_W-1:0]     elapsed_ms = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic                            was_pushing;
	logic                            solenoid_on;
	logic                            cfg_we = 1'b0;
	logic [sbp_pkg::CFG_INDEX_W-1:0] cfg_index = sbp_pkg::REG_SPEED_MIN;
	logic [sbp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	pulse_tracker tracker;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int n_requests = 0;
	int n_starts = 0;
	int n_halts = 0;

	solenoid_burst_pulser uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.speed      (speed),
		.shot_count (shot_count),
		.elapsed_ms (elapsed_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.was_pushing(was_pushing),
		.solenoid_on(solenoid_on),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stall the result side at random, or hold off for a long stretch on demand
	always @(posedge clk) begin
		if (hold_len != 0) begin
			hold_left = hold_len;
			hold_len = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_levels(was_pushing, solenoid_on);
	end

	// Offer one request after a random gap; leave valid high on return
	task automatic offer(input sbp_pkg::cmd_t c, input logic [15:0] spd,
			input logic [15:0] shots, input logic [15:0] el);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		speed <= spd;
		shot_count <= shots;
		elapsed_ms <= el;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_request(c, spd, shots, el);
		n_requests++;
		if (c == sbp_pkg::CMD_AUTO || c == sbp_pkg::CMD_BURST)
			n_starts++;
		if (c == sbp_pkg::CMD_HALT)
			n_halts++;
	endtask

	task automatic cfg_write(input logic [sbp_pkg::CFG_INDEX_W-1:0] idx,
			input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		tracker.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] ef, input logic [15:0] es, input logic [15:0] rf,
			input logic [15:0] rs, input bit spare);
		cfg_write(sbp_pkg::REG_SPEED_MIN, lo);
		cfg_write(sbp_pkg::REG_SPEED_MAX, hi);
		cfg_write(sbp_pkg::REG_EXTEND_FAST, ef);
		cfg_write(sbp_pkg::REG_EXTEND_SLOW, es);
		cfg_write(sbp_pkg::REG_RETRACT_FAST, rf);
		cfg_write(sbp_pkg::REG_RETRACT_SLOW, rs);
		if (spare) begin
			cfg_write(REG_SPARE_LO, 16'($urandom));
			cfg_write(REG_SPARE_HI, 16'($urandom));
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] rand_time();
		if ($urandom_range(4) == 0)
			return 16'($urandom);
		return 16'($urandom_range(60));
	endfunction

	task automatic random_regs();
		logic [15:0] lo, hi;
		lo = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(300));
		hi = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(300));
		program_regs(lo, hi, rand_time(), rand_time(), rand_time(), rand_time(), 1'b1);
	endtask

	// Drop valid and wait for every result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly ticks with some starts and halts; field values from small to full range
	task automatic send_random();
		int r, lo, hi;
		sbp_pkg::cmd_t c;
		logic [15:0] spd, shots, el;
		r = $urandom_range(99);
		if (r < 72)
			c = sbp_pkg::CMD_TICK;
		else if (r < 80)
			c = sbp_pkg::CMD_AUTO;
		else if (r < 92)
			c = sbp_pkg::CMD_BURST;
		else
			c = sbp_pkg::CMD_HALT;

		lo = int'(tracker.spd_lo);
		hi = int'(tracker.spd_hi);
		r = $urandom_range(99);
		if (r < 55)
			spd = 16'($urandom_range((lo > 5) ? lo - 5 : 0, (hi < 65530) ? hi + 5 : 65535));
		else if (r < 75)
			spd = 16'($urandom);
		else
			case ($urandom_range(3))
				0: spd = 16'h0000;
				1: spd = 16'hFFFF;
				2: spd = tracker.spd_lo;
				default: spd = tracker.spd_hi;
			endcase

		r = $urandom_range(99);
		if (r < 70)
			shots = 16'($urandom_range(1, 4));
		else if (r < 80)
			shots = '0;
		else
			shots = 16'($urandom);

		r = $urandom_range(99);
		if (r < 10)
			el = '0;
		else if (r < 80)
			el = 16'($urandom_range(1, 40));
		else if (r < 90)
			el = 16'($urandom_range(100, 1000));
		else
			el = 16'($urandom);

		offer(c, spd, shots, el);
	endtask

	initial begin
		tracker = new();

		// Hold reset at the start, then release it
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass under the reset register values
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'd0);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'd5);
		offer(sbp_pkg::CMD_HALT,  16'd0,     16'd0,     16'd0);
		offer(sbp_pkg::CMD_AUTO,  16'd0,     16'd0,     16'd0);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'd1);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'd0);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'hFFFF);
		offer(sbp_pkg::CMD_AUTO,  16'hFFFF,  16'd0,     16'd0);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'd30);
		offer(sbp_pkg::CMD_BURST, 16'd50,    16'd2,     16'd0);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'hFFFF);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'hFFFF);
		offer(sbp_pkg::CMD_BURST, 16'd100,   16'd3,     16'd0);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'd7);
		offer(sbp_pkg::CMD_HALT,  16'd0,     16'd0,     16'd0);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'd0);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'd3);
		offer(sbp_pkg::CMD_BURST, 16'd0,     16'd0,     16'd0);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'd200);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'd200);
		offer(sbp_pkg::CMD_HALT,  16'hFFFF,  16'hFFFF,  16'hFFFF);
		offer(sbp_pkg::CMD_TICK,  16'd0,     16'd0,     16'd1);
		offer(sbp_pkg::CMD_BURST, 16'hFFFF,  16'hFFFF,  16'd0);
		offer(sbp_pkg::CMD_TICK,  16'hFFFF,  16'hFFFF,  16'hFFFF);
		offer(sbp_pkg::CMD_HALT,  16'd0,     16'd0,     16'd0);
		drain();

		// Random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 3) begin
				send_idle_pct = 32;
				recv_stall_pct = 80;
			end else if (ph < 6) begin
				send_idle_pct = 80;
				recv_stall_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end

			case (ph)
				0: program_regs(16'd10, 16'd50, 16'd3, 16'd40, 16'd5, 16'd60, 1'b1);
				1: program_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b0);
				2: program_regs(16'hFFFF, 16'd0, 16'd12, 16'd30, 16'd9, 16'd25, 1'b0);
				3: program_regs(16'd200, 16'd200, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
				5: program_regs(sbp_pkg::SPEED_MIN_RST, sbp_pkg::SPEED_MAX_RST,
					sbp_pkg::EXTEND_FAST_RST, sbp_pkg::EXTEND_SLOW_RST,
					sbp_pkg::RETRACT_FAST_RST, sbp_pkg::RETRACT_SLOW_RST, 1'b1);
				7: program_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
				default: random_regs();
			endcase

			// Back up the result side while requests keep coming
			if (ph == 6)
				hold_len = LONG_HOLD_CYCLES;

			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_random();
			drain();
		end

		if (tracker.pending() != 0) begin
			$error("%0d expected results never arrived", tracker.pending());
			tracker.errors++;
		end

		$display("Covered %0d requests (%0d starts, %0d halts), %0d results checked,",
			n_requests, n_starts, n_halts, tracker.n_checked);
		$display("%0d drive toggles over %0d register settings.", tracker.n_toggles, PHASES + 1);
		if (tracker.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
